// ===== hw/rtl/jbe_pkg.sv =====
// ----------------------------------------------------------------------------
// jbe_pkg
// Shared sizes, opcode and status codes, and the decode record of the
// integer bytecode executor.
// ----------------------------------------------------------------------------
package jbe_pkg;

  localparam int STACK_SLOTS = 64;
  localparam int LOCAL_SLOTS = 256;

  localparam int SP_W = $clog2(STACK_SLOTS + 1);  // stack pointer, holds 0..STACK_SLOTS
  localparam int SA_W = $clog2(STACK_SLOTS);      // stack memory address
  localparam int LC_W = $clog2(LOCAL_SLOTS + 1);  // local count in force
  localparam int LA_W = $clog2(LOCAL_SLOTS);      // locals memory address

  localparam int LIMIT_W = 7;  // stack_limit register
  localparam int COUNT_W = 9;  // local_count register
  localparam int CFG_W   = 9;  // config write data
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_STACK_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_COUNT = 1'd1;

  localparam logic [LIMIT_W-1:0] STACK_LIMIT_RST = 7'd64;
  localparam logic [COUNT_W-1:0] LOCAL_COUNT_RST = 9'd256;

  // JVM opcodes
  localparam logic [7:0] OP_ICONST_0 = 8'h03;
  localparam logic [7:0] OP_ICONST_1 = 8'h04;
  localparam logic [7:0] OP_BIPUSH   = 8'h10;
  localparam logic [7:0] OP_ILOAD_0  = 8'h1A;
  localparam logic [7:0] OP_ILOAD_1  = 8'h1B;
  localparam logic [7:0] OP_ILOAD_2  = 8'h1C;
  localparam logic [7:0] OP_ISTORE_0 = 8'h3B;
  localparam logic [7:0] OP_ISTORE_1 = 8'h3C;
  localparam logic [7:0] OP_ISTORE_2 = 8'h3D;
  localparam logic [7:0] OP_IADD     = 8'h60;
  localparam logic [7:0] OP_IINC     = 8'h84;
  localparam logic [7:0] OP_ICMP_GT  = 8'hA3;
  localparam logic [7:0] OP_GOTO     = 8'hA7;
  localparam logic [7:0] OP_IRETURN  = 8'hAC;

  // result status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_UNDER    = 3'd2;
  localparam logic [2:0] ST_OVER     = 3'd3;
  localparam logic [2:0] ST_BADLOCAL = 3'd4;

  // instruction classes
  localparam logic [3:0] CL_NONE    = 4'd0;
  localparam logic [3:0] CL_ICONST  = 4'd1;
  localparam logic [3:0] CL_BIPUSH  = 4'd2;
  localparam logic [3:0] CL_ILOAD   = 4'd3;
  localparam logic [3:0] CL_ISTORE  = 4'd4;
  localparam logic [3:0] CL_IADD    = 4'd5;
  localparam logic [3:0] CL_IINC    = 4'd6;
  localparam logic [3:0] CL_ICMPGT  = 4'd7;
  localparam logic [3:0] CL_GOTO    = 4'd8;
  localparam logic [3:0] CL_IRETURN = 4'd9;

  typedef struct packed {
    logic [3:0] cls;     // instruction class
    logic [2:0] status;  // fault found by the checks, ST_OK if none
    logic [1:0] idx;     // local index of the _0.._2 forms, iconst value
  } dec_t;

endpackage

// ===== hw/rtl/jvm_int_bytecode_executor_unit.sv =====
// ----------------------------------------------------------------------------
// jvm_int_bytecode_executor_unit
// Integer-subset JVM stack machine: one instruction per request, one
// result per request.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*  : one request = opcode byte plus the two bytes after it.
//  - out_* : one result per request: next pc, halted, ireturn value, status.
//  - cfg_* : writes stack_limit (index 0) or local_count (index 1); always
//            ready, to be used only while the block is idle.
// Timing: the operand stack and the locals each sit in a one-port-read,
//  one-port-write RAM with registered read. A request that reads no memory
//  (push of a constant, goto, faults, requests after a stop) gets its result
//  straight from S_DEC; one with one read goes S_DEC then S_EXE; one that
//  needs both top stack entries (iadd, the signed compare-and-branch) goes
//  S_DEC, S_RD2, S_EXE, since they come through the single stack read port in
//  turn. One request is in flight at a time, so a new request is taken only
//  once the last one has committed; its write-back lands before the next
//  request can read, so no forwarding.
// Stall: the result sits in an output register; a further request is taken
//  while it waits, but that request's result (and its write-back) holds
//  until the register is free.
// Reset: pc, stack pointer and stop flag clear, limits go to 64 and 256.
//  Stack and locals memories are not cleared; a never-written local reads
//  as whatever the RAM holds.
// ----------------------------------------------------------------------------
module jvm_int_bytecode_executor_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_opcode,
  input  logic [7:0]                      in_operand_hi,
  input  logic [7:0]                      in_operand_lo,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_next_pc,
  output logic                            out_halted,
  output logic signed [31:0]              out_return_value,
  output logic [2:0]                      out_status,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jbe_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_DEC  = 3'd1;  // checks, first memory read
  localparam logic [2:0] S_RD2  = 3'd2;  // second stack read
  localparam logic [2:0] S_EXE  = 3'd3;  // compute and write back

  localparam int LIM_CMP_W = (jbe_pkg::SP_W > jbe_pkg::LIMIT_W) ?
                             jbe_pkg::SP_W : jbe_pkg::LIMIT_W;

  logic [2:0]                   state_r, state_nxt;
  logic [7:0]                   op_r, op_nxt;
  logic [7:0]                   hi_r, hi_nxt;
  logic [7:0]                   lo_r, lo_nxt;
  logic [15:0]                  pc_r, pc_nxt;
  logic [jbe_pkg::SP_W-1:0]     sp_r, sp_nxt;
  logic                         stopped_r, stopped_nxt;
  logic [31:0]                  b_r, b_nxt;
  logic [jbe_pkg::LIMIT_W-1:0]  stack_limit_r, stack_limit_nxt;
  logic [jbe_pkg::COUNT_W-1:0]  local_count_r, local_count_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [15:0]                  out_pc_r, out_pc_nxt;
  logic                         out_halted_r, out_halted_nxt;
  logic [31:0]                  out_ret_r, out_ret_nxt;
  logic [2:0]                   out_status_r, out_status_nxt;

  // limits in force
  logic [LIM_CMP_W-1:0]         limit_ext;
  logic [jbe_pkg::SP_W-1:0]     depth;
  logic [jbe_pkg::LC_W-1:0]     nloc;

  jbe_pkg::dec_t                dec;

  logic [jbe_pkg::SP_W-1:0]     sp_m1;
  logic [jbe_pkg::SP_W-1:0]     sp_m2;
  logic [15:0]                  offset;
  logic                         needs_read;
  logic                         two_reads;
  logic                         out_free;
  logic                         commit;

  // memory ports
  logic                         stk_we, stk_re;
  logic [jbe_pkg::SA_W-1:0]     stk_waddr, stk_raddr;
  logic [31:0]                  stk_wdata, stk_rdata;
  logic                         loc_we, loc_re;
  logic [jbe_pkg::LA_W-1:0]     loc_waddr, loc_raddr;
  logic [31:0]                  loc_wdata, loc_rdata;

  // outcome of the instruction, applied on commit
  logic [15:0]                  r_pc;
  logic [jbe_pkg::SP_W-1:0]     r_sp;
  logic                         r_stop;
  logic [31:0]                  r_ret;
  logic [2:0]                   r_status;
  logic                         r_stk_we;
  logic [jbe_pkg::SA_W-1:0]     r_stk_addr;
  logic [31:0]                  r_stk_data;
  logic                         r_loc_we;
  logic [jbe_pkg::LA_W-1:0]     r_loc_addr;
  logic [31:0]                  r_loc_data;

  assign limit_ext = LIM_CMP_W'(stack_limit_r);
  assign depth = (limit_ext < LIM_CMP_W'(jbe_pkg::STACK_SLOTS)) ?
                 jbe_pkg::SP_W'(limit_ext) : jbe_pkg::SP_W'(jbe_pkg::STACK_SLOTS);
  assign nloc  = (local_count_r < jbe_pkg::COUNT_W'(jbe_pkg::LOCAL_SLOTS)) ?
                 jbe_pkg::LC_W'(local_count_r) : jbe_pkg::LC_W'(jbe_pkg::LOCAL_SLOTS);

  assign sp_m1  = sp_r - jbe_pkg::SP_W'(1);
  assign sp_m2  = sp_r - jbe_pkg::SP_W'(2);
  assign offset = {hi_r, lo_r};

  jbe_decode u_decode (
    .opcode     (op_r),
    .operand_hi (hi_r),
    .sp         (sp_r),
    .depth      (depth),
    .nloc       (nloc),
    .dec        (dec)
  );

  jbe_ram #(
    .WIDTH (32),
    .DEPTH (jbe_pkg::STACK_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  jbe_ram #(
    .WIDTH (32),
    .DEPTH (jbe_pkg::LOCAL_SLOTS)
  ) u_local_ram (
    .clk   (clk),
    .we    (loc_we),
    .waddr (loc_waddr),
    .wdata (loc_wdata),
    .re    (loc_re),
    .raddr (loc_raddr),
    .rdata (loc_rdata)
  );

  // Instructions that read no memory finish straight out of decode.
  assign needs_read = !stopped_r && (dec.status == jbe_pkg::ST_OK) &&
                      (dec.cls == jbe_pkg::CL_ILOAD  || dec.cls == jbe_pkg::CL_ISTORE ||
                       dec.cls == jbe_pkg::CL_IADD   || dec.cls == jbe_pkg::CL_IINC   ||
                       dec.cls == jbe_pkg::CL_ICMPGT || dec.cls == jbe_pkg::CL_IRETURN);
  assign two_reads  = (dec.cls == jbe_pkg::CL_IADD) || (dec.cls == jbe_pkg::CL_ICMPGT);

  assign out_free = !out_valid_r || out_ready;
  assign commit   = out_free &&
                    ((state_r == S_DEC && !needs_read) || state_r == S_EXE);

  // Outcome. In S_EXE the stack read data holds stack[sp-1] for single-read
  // ops and stack[sp-2] for two-read ops, whose top entry sits in b_r.
  always_comb begin
    r_pc       = pc_r;
    r_sp       = sp_r;
    r_stop     = stopped_r;
    r_ret      = '0;
    r_status   = jbe_pkg::ST_OK;
    r_stk_we   = 1'b0;
    r_stk_addr = sp_r[jbe_pkg::SA_W-1:0];
    r_stk_data = '0;
    r_loc_we   = 1'b0;
    r_loc_addr = jbe_pkg::LA_W'(dec.idx);
    r_loc_data = stk_rdata;
    if (stopped_r) begin
      r_stop = 1'b1;
    end else if (dec.status != jbe_pkg::ST_OK) begin
      r_status = dec.status;
      r_stop   = 1'b1;
    end else begin
      case (dec.cls)
        jbe_pkg::CL_ICONST: begin
          r_stk_we   = 1'b1;
          r_stk_data = 32'(dec.idx);
          r_sp       = sp_r + jbe_pkg::SP_W'(1);
          r_pc       = pc_r + 16'd1;
        end
        jbe_pkg::CL_BIPUSH: begin
          r_stk_we   = 1'b1;
          r_stk_data = {{24{hi_r[7]}}, hi_r};
          r_sp       = sp_r + jbe_pkg::SP_W'(1);
          r_pc       = pc_r + 16'd2;
        end
        jbe_pkg::CL_ILOAD: begin
          r_stk_we   = 1'b1;
          r_stk_data = loc_rdata;
          r_sp       = sp_r + jbe_pkg::SP_W'(1);
          r_pc       = pc_r + 16'd1;
        end
        jbe_pkg::CL_ISTORE: begin
          r_loc_we = 1'b1;
          r_sp     = sp_m1;
          r_pc     = pc_r + 16'd1;
        end
        jbe_pkg::CL_IADD: begin
          r_stk_we   = 1'b1;
          r_stk_addr = sp_m2[jbe_pkg::SA_W-1:0];
          r_stk_data = stk_rdata + b_r;
          r_sp       = sp_m1;
          r_pc       = pc_r + 16'd1;
        end
        jbe_pkg::CL_IINC: begin
          r_loc_we   = 1'b1;
          r_loc_addr = hi_r[jbe_pkg::LA_W-1:0];
          r_loc_data = loc_rdata + {{24{lo_r[7]}}, lo_r};
          r_pc       = pc_r + 16'd3;
        end
        jbe_pkg::CL_ICMPGT: begin
          r_sp = sp_m2;
          r_pc = ($signed(stk_rdata) > $signed(b_r)) ? pc_r + offset : pc_r + 16'd3;
        end
        jbe_pkg::CL_GOTO: begin
          r_pc = pc_r + offset;
        end
        jbe_pkg::CL_IRETURN: begin
          r_ret  = stk_rdata;
          r_sp   = sp_m1;
          r_pc   = pc_r + 16'd1;
          r_stop = 1'b1;
        end
        default: begin
          r_stop = 1'b1;
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    pc_nxt          = pc_r;
    sp_nxt          = sp_r;
    stopped_nxt     = stopped_r;
    b_nxt           = b_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_pc_nxt      = out_pc_r;
    out_halted_nxt  = out_halted_r;
    out_ret_nxt     = out_ret_r;
    out_status_nxt  = out_status_r;
    stk_re          = 1'b0;
    stk_raddr       = sp_m1[jbe_pkg::SA_W-1:0];
    loc_re          = 1'b0;
    loc_raddr       = jbe_pkg::LA_W'(dec.idx);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          hi_nxt    = in_operand_hi;
          lo_nxt    = in_operand_lo;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (needs_read) begin
          stk_re    = 1'b1;
          loc_re    = (dec.cls == jbe_pkg::CL_ILOAD) || (dec.cls == jbe_pkg::CL_IINC);
          if (dec.cls == jbe_pkg::CL_IINC) begin
            loc_raddr = hi_r[jbe_pkg::LA_W-1:0];
          end
          state_nxt = two_reads ? S_RD2 : S_EXE;
        end else if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD2: begin
        b_nxt     = stk_rdata;
        stk_re    = 1'b1;
        stk_raddr = sp_m2[jbe_pkg::SA_W-1:0];
        state_nxt = S_EXE;
      end
      S_EXE: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (commit) begin
      pc_nxt         = r_pc;
      sp_nxt         = r_sp;
      stopped_nxt    = r_stop;
      out_valid_nxt  = 1'b1;
      out_pc_nxt     = r_pc;
      out_halted_nxt = r_stop;
      out_ret_nxt    = r_ret;
      out_status_nxt = r_status;
    end
  end

  assign stk_we    = commit && r_stk_we;
  assign stk_waddr = r_stk_addr;
  assign stk_wdata = r_stk_data;
  assign loc_we    = commit && r_loc_we;
  assign loc_waddr = r_loc_addr;
  assign loc_wdata = r_loc_data;

  // Configuration registers
  always_comb begin
    stack_limit_nxt = stack_limit_r;
    local_count_nxt = local_count_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        jbe_pkg::REG_STACK_LIMIT: stack_limit_nxt = cfg_wdata[jbe_pkg::LIMIT_W-1:0];
        jbe_pkg::REG_LOCAL_COUNT: local_count_nxt = cfg_wdata[jbe_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pc_r          <= '0;
      sp_r          <= '0;
      stopped_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      stack_limit_r <= jbe_pkg::STACK_LIMIT_RST;
      local_count_r <= jbe_pkg::LOCAL_COUNT_RST;
    end else begin
      state_r       <= state_nxt;
      pc_r          <= pc_nxt;
      sp_r          <= sp_nxt;
      stopped_r     <= stopped_nxt;
      out_valid_r   <= out_valid_nxt;
      stack_limit_r <= stack_limit_nxt;
      local_count_r <= local_count_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    b_r          <= b_nxt;
    out_pc_r     <= out_pc_nxt;
    out_halted_r <= out_halted_nxt;
    out_ret_r    <= out_ret_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_pc_r;
  assign out_halted       = out_halted_r;
  assign out_return_value = $signed(out_ret_r);
  assign out_status       = out_status_r;

endmodule

// ===== hw/rtl/jbe_ram.sv =====
// ----------------------------------------------------------------------------
// jbe_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module jbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/jbe_decode.sv =====
// ----------------------------------------------------------------------------
// jbe_decode
// Opcode decode and fault checks: local index first, then underflow,
// then overflow.
// ----------------------------------------------------------------------------
module jbe_decode (
  input  logic [7:0]               opcode,
  input  logic [7:0]               operand_hi,
  input  logic [jbe_pkg::SP_W-1:0] sp,
  input  logic [jbe_pkg::SP_W-1:0] depth,
  input  logic [jbe_pkg::LC_W-1:0] nloc,
  output jbe_pkg::dec_t            dec
);

  logic [7:0] ld_diff;
  logic [7:0] st_diff;
  logic       full;
  logic       below_two;

  assign ld_diff   = opcode - jbe_pkg::OP_ILOAD_0;
  assign st_diff   = opcode - jbe_pkg::OP_ISTORE_0;
  assign full      = (sp >= depth);
  assign below_two = (sp < jbe_pkg::SP_W'(2));

  always_comb begin
    dec.cls    = jbe_pkg::CL_NONE;
    dec.status = jbe_pkg::ST_OK;
    dec.idx    = '0;
    unique case (opcode) inside
      jbe_pkg::OP_ICONST_0, jbe_pkg::OP_ICONST_1: begin
        dec.cls = jbe_pkg::CL_ICONST;
        dec.idx = {1'b0, opcode[0] ^ jbe_pkg::OP_ICONST_0[0]};
        if (full) dec.status = jbe_pkg::ST_OVER;
      end
      jbe_pkg::OP_BIPUSH: begin
        dec.cls = jbe_pkg::CL_BIPUSH;
        if (full) dec.status = jbe_pkg::ST_OVER;
      end
      jbe_pkg::OP_ILOAD_0, jbe_pkg::OP_ILOAD_1, jbe_pkg::OP_ILOAD_2: begin
        dec.cls = jbe_pkg::CL_ILOAD;
        dec.idx = ld_diff[1:0];
        if (jbe_pkg::COUNT_W'(ld_diff[1:0]) >= jbe_pkg::COUNT_W'(nloc)) begin
          dec.status = jbe_pkg::ST_BADLOCAL;
        end else if (full) begin
          dec.status = jbe_pkg::ST_OVER;
        end
      end
      jbe_pkg::OP_ISTORE_0, jbe_pkg::OP_ISTORE_1, jbe_pkg::OP_ISTORE_2: begin
        dec.cls = jbe_pkg::CL_ISTORE;
        dec.idx = st_diff[1:0];
        if (jbe_pkg::COUNT_W'(st_diff[1:0]) >= jbe_pkg::COUNT_W'(nloc)) begin
          dec.status = jbe_pkg::ST_BADLOCAL;
        end else if (sp == '0) begin
          dec.status = jbe_pkg::ST_UNDER;
        end
      end
      jbe_pkg::OP_IADD: begin
        dec.cls = jbe_pkg::CL_IADD;
        if (below_two) dec.status = jbe_pkg::ST_UNDER;
      end
      jbe_pkg::OP_IINC: begin
        dec.cls = jbe_pkg::CL_IINC;
        if (jbe_pkg::COUNT_W'(operand_hi) >= jbe_pkg::COUNT_W'(nloc)) begin
          dec.status = jbe_pkg::ST_BADLOCAL;
        end
      end
      jbe_pkg::OP_ICMP_GT: begin
        dec.cls = jbe_pkg::CL_ICMPGT;
        if (below_two) dec.status = jbe_pkg::ST_UNDER;
      end
      jbe_pkg::OP_GOTO: begin
        dec.cls = jbe_pkg::CL_GOTO;
      end
      jbe_pkg::OP_IRETURN: begin
        dec.cls = jbe_pkg::CL_IRETURN;
        if (sp == '0) dec.status = jbe_pkg::ST_UNDER;
      end
      default: begin
        dec.status = jbe_pkg::ST_UNKNOWN;
      end
    endcase
  end

endmodule
